// File: src/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types and constants for the DMA ring drain controller.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

  localparam int unsigned RING_BYTES_DEF      = 2097152;
  localparam int unsigned SOFT_FIFO_BYTES_DEF = 536870912;

  localparam int unsigned SOFT_MARGIN = 129;
  localparam int unsigned ALIGN_BYTES = 128;

  localparam logic [19:0] INTERVAL_RESET        = 20'd1000;
  localparam logic [31:0] DMA_BASE_RESET        = 32'd0;
  localparam logic [20:0] BUSY_THRESHOLD_RESET  = 21'd1572864;
  localparam logic [19:0] INTERVAL_STEP_RESET   = 20'd1000;
  localparam logic [19:0] INTERVAL_MIN_RESET    = 20'd10000;
  localparam logic [19:0] INTERVAL_MAX_RESET    = 20'd100000;
  localparam logic [21:0] MAX_WRITE_BYTES_RESET = 22'd2097152;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_POLL    = 2'd1,
    OP_CONSUME = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DMA_BASE        = 3'd0,
    CFG_BUSY_THRESHOLD  = 3'd1,
    CFG_INTERVAL_STEP   = 3'd2,
    CFG_INTERVAL_MIN    = 3'd3,
    CFG_INTERVAL_MAX    = 3'd4,
    CFG_MAX_WRITE_BYTES = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] hw_write_address;
    logic [21:0] written_count;
  } item_t;

  typedef struct packed {
    logic [31:0] dma_base;
    logic [20:0] busy_threshold;
    logic [19:0] interval_step_us;
    logic [19:0] interval_min_us;
    logic [19:0] interval_max_us;
  } cfg_t;

  typedef struct packed {
    logic [20:0] copy_source_offset;
    logic [28:0] copy_dest_offset;
    logic [20:0] first_length;
    logic [20:0] second_length;
    logic        wake_writer;
    logic        hard_overflow;
  } step_t;

  typedef struct packed {
    logic [20:0] copy_source_offset;
    logic [28:0] copy_dest_offset;
    logic [20:0] first_length;
    logic [20:0] second_length;
    logic        wake_writer;
    logic [19:0] poll_interval_us;
    logic        hard_overflow;
    logic        failed;
    logic [29:0] fill_bytes;
    logic [21:0] next_write_length;
    logic        drained_after_failure;
  } result_t;

endpackage

`default_nettype wire

// File: src/drc_item_if.sv
// ----------------------------------------------------------------------------
// drc_item_if
// Input channel: one command transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface drc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] hw_write_address;
  logic [21:0] written_count;

  modport source (
    output valid, opcode, hw_write_address, written_count,
    input  ready
  );

  modport sink (
    input  valid, opcode, hw_write_address, written_count,
    output ready
  );
endinterface

`default_nettype wire

// File: src/drc_result_if.sv
// ----------------------------------------------------------------------------
// drc_result_if
// Output channel: one result transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface drc_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] copy_source_offset;
  logic [28:0] copy_dest_offset;
  logic [20:0] first_length;
  logic [20:0] second_length;
  logic        wake_writer;
  logic [19:0] poll_interval_us;
  logic        hard_overflow;
  logic        failed;
  logic [29:0] fill_bytes;
  logic [21:0] next_write_length;
  logic        drained_after_failure;

  modport source (
    output valid, copy_source_offset, copy_dest_offset, first_length, second_length,
           wake_writer, poll_interval_us, hard_overflow, failed, fill_bytes,
           next_write_length, drained_after_failure,
    input  ready
  );

  modport sink (
    input  valid, copy_source_offset, copy_dest_offset, first_length, second_length,
           wake_writer, poll_interval_us, hard_overflow, failed, fill_bytes,
           next_write_length, drained_after_failure,
    output ready
  );
endinterface

`default_nettype wire

// File: src/dma_ring_drain_controller.sv
// ----------------------------------------------------------------------------
// dma_ring_drain_controller
// Bookkeeping for draining a DMA ring into a soft FIFO and feeding a writer.
//
// Usage:
//   item_i carries start, poll and consume commands; result_o returns exactly
//   one result transaction per command, in order. Configuration registers are
//   written through cfg_we_i / cfg_index_i / cfg_wdata_i, by the user only while
//   the block is idle (not enforced by the block); unknown indexes are ignored.
//   Pipeline: two register stages, step_q then result_q; a result is loaded
//   into result_q from the step_q stage once result_o can advance.
//   Throughput: one command per cycle while result_o is not stalled. The state
//   update is registered at acceptance; the writer chunk length is formed in the
//   following stage from the updated FIFO pointers.
//   Reset clears the ring and FIFO pointers, the fill and the failed flag,
//   loads the poll interval with 1000 and the registers with their defaults.
//   When result_o stalls, up to two commands stay held in the pipeline, then
//   item_i.ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_ring_drain_controller #(
  parameter int unsigned RING_BYTES      = drc_pkg::RING_BYTES_DEF,
  parameter int unsigned SOFT_FIFO_BYTES = drc_pkg::SOFT_FIFO_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [drc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [drc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  drc_item_if.sink                              item_i,
  drc_result_if.source                          result_o
);

  localparam int unsigned FIFO_W = $clog2(SOFT_FIFO_BYTES);
  localparam int unsigned FILL_W = $clog2(SOFT_FIFO_BYTES + 1);
  localparam int unsigned LCMP_W = (FIFO_W + 1 > 22) ? FIFO_W + 1 : 22;

  drc_pkg::cfg_t     cfg_q;
  logic [21:0]       max_write_q;

  drc_pkg::item_t    item;
  drc_pkg::step_t    step;
  drc_pkg::step_t    step_q;
  logic              step_valid_q;
  drc_pkg::result_t  result_d, result_q;
  logic              result_valid_q;

  logic              accept;
  logic              advance;

  logic [FIFO_W-1:0] put;
  logic [FIFO_W-1:0] get;
  logic [FILL_W-1:0] fill;
  logic              failed;
  logic [19:0]       interval;
  logic [FIFO_W:0]   chunk;
  logic [21:0]       chunk_capped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dma_base         <= drc_pkg::DMA_BASE_RESET;
      cfg_q.busy_threshold   <= drc_pkg::BUSY_THRESHOLD_RESET;
      cfg_q.interval_step_us <= drc_pkg::INTERVAL_STEP_RESET;
      cfg_q.interval_min_us  <= drc_pkg::INTERVAL_MIN_RESET;
      cfg_q.interval_max_us  <= drc_pkg::INTERVAL_MAX_RESET;
      max_write_q            <= drc_pkg::MAX_WRITE_BYTES_RESET;
    end else if (cfg_we_i) begin
      case (drc_pkg::cfg_index_e'(cfg_index_i))
        drc_pkg::CFG_DMA_BASE:        cfg_q.dma_base         <= cfg_wdata_i;
        drc_pkg::CFG_BUSY_THRESHOLD:  cfg_q.busy_threshold   <= cfg_wdata_i[20:0];
        drc_pkg::CFG_INTERVAL_STEP:   cfg_q.interval_step_us <= cfg_wdata_i[19:0];
        drc_pkg::CFG_INTERVAL_MIN:    cfg_q.interval_min_us  <= cfg_wdata_i[19:0];
        drc_pkg::CFG_INTERVAL_MAX:    cfg_q.interval_max_us  <= cfg_wdata_i[19:0];
        drc_pkg::CFG_MAX_WRITE_BYTES: max_write_q            <= cfg_wdata_i[21:0];
        default: begin
        end
      endcase
    end
  end

  assign advance      = !result_valid_q || result_o.ready;
  assign item_i.ready = !step_valid_q || advance;
  assign accept       = item_i.valid && item_i.ready;

  assign item.opcode           = item_i.opcode;
  assign item.hw_write_address = item_i.hw_write_address;
  assign item.written_count    = item_i.written_count;

  drc_state #(
    .RING_BYTES      (RING_BYTES),
    .SOFT_FIFO_BYTES (SOFT_FIFO_BYTES)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .step_o     (step),
    .put_o      (put),
    .get_o      (get),
    .fill_o     (fill),
    .failed_o   (failed),
    .interval_o (interval)
  );

  // State registers always match the command held in the first stage.
  always_comb begin
    if (put > get) begin
      chunk = {1'b0, put - get};
    end else begin
      chunk = (FIFO_W + 1)'(SOFT_FIFO_BYTES) - {1'b0, get};
    end
    if (fill == '0) begin
      chunk_capped = '0;
    end else if (LCMP_W'(chunk) > LCMP_W'(max_write_q)) begin
      chunk_capped = max_write_q;
    end else begin
      chunk_capped = 22'(chunk);
    end

    result_d.copy_source_offset    = step_q.copy_source_offset;
    result_d.copy_dest_offset      = step_q.copy_dest_offset;
    result_d.first_length          = step_q.first_length;
    result_d.second_length         = step_q.second_length;
    result_d.wake_writer           = step_q.wake_writer;
    result_d.poll_interval_us      = interval;
    result_d.hard_overflow         = step_q.hard_overflow;
    result_d.failed                = failed;
    result_d.fill_bytes            = 30'(fill);
    result_d.next_write_length     = chunk_capped;
    result_d.drained_after_failure = failed && (fill == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        step_valid_q <= item_i.valid;
      end
      if (advance) begin
        result_valid_q <= step_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_q <= step;
    end
    if (advance && step_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid                 = result_valid_q;
  assign result_o.copy_source_offset    = result_q.copy_source_offset;
  assign result_o.copy_dest_offset      = result_q.copy_dest_offset;
  assign result_o.first_length          = result_q.first_length;
  assign result_o.second_length         = result_q.second_length;
  assign result_o.wake_writer           = result_q.wake_writer;
  assign result_o.poll_interval_us      = result_q.poll_interval_us;
  assign result_o.hard_overflow         = result_q.hard_overflow;
  assign result_o.failed                = result_q.failed;
  assign result_o.fill_bytes            = result_q.fill_bytes;
  assign result_o.next_write_length     = result_q.next_write_length;
  assign result_o.drained_after_failure = result_q.drained_after_failure;

endmodule

`default_nettype wire

// File: src/drc_state.sv
// ----------------------------------------------------------------------------
// drc_state
// Ring and soft FIFO bookkeeping registers with their single-pass update.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_state #(
  parameter int unsigned RING_BYTES      = drc_pkg::RING_BYTES_DEF,
  parameter int unsigned SOFT_FIFO_BYTES = drc_pkg::SOFT_FIFO_BYTES_DEF,
  localparam int unsigned RING_W = $clog2(RING_BYTES),
  localparam int unsigned FIFO_W = $clog2(SOFT_FIFO_BYTES),
  localparam int unsigned FILL_W = $clog2(SOFT_FIFO_BYTES + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire drc_pkg::item_t        item_i,
  input  wire drc_pkg::cfg_t         cfg_i,
  output drc_pkg::step_t             step_o,
  output logic [FIFO_W-1:0]          put_o,
  output logic [FIFO_W-1:0]          get_o,
  output logic [FILL_W-1:0]          fill_o,
  output logic                       failed_o,
  output logic [19:0]                interval_o
);

  localparam int unsigned NCMP_W = (FILL_W > RING_W) ? FILL_W : RING_W;
  localparam int unsigned PSUM_W = ((FIFO_W > RING_W) ? FIFO_W : RING_W) + 1;
  localparam int unsigned CCMP_W = (FILL_W > 22) ? FILL_W : 22;
  localparam logic [FILL_W-1:0] SOFT_LIMIT =
    FILL_W'(SOFT_FIFO_BYTES - drc_pkg::SOFT_MARGIN);
  localparam logic [FILL_W-1:0] ALIGN_KEEP = ~FILL_W'(drc_pkg::ALIGN_BYTES - 1);

  logic [RING_W-1:0] rro_q, rro_d;
  logic [FIFO_W-1:0] put_q, put_d;
  logic [FIFO_W-1:0] get_q, get_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              failed_q, failed_d;
  logic [19:0]       interval_q, interval_d;

  logic [31:0]       cur;
  logic [RING_W-1:0] cur_aligned;
  logic [RING_W-1:0] n_raw;
  logic [FILL_W-1:0] room;
  logic [FILL_W-1:0] room_aligned;
  logic              room_clamp;
  logic [RING_W-1:0] n;
  logic [RING_W:0]   ring_sum;
  logic              wraps;
  logic [RING_W:0]   to_wrap;
  logic [RING_W-1:0] len1;
  logic [RING_W-1:0] len2;
  logic [PSUM_W-1:0] put_sum;
  logic [FIFO_W-1:0] put_poll;
  logic [FILL_W-1:0] fill_poll;
  logic [20:0]       iv_up;
  logic [20:0]       iv_raw;
  logic [19:0]       iv_clamped;
  logic [FILL_W-1:0] retire;
  logic [FIFO_W:0]   get_sum;
  logic [FIFO_W-1:0] get_cons;

  always_comb begin
    cur          = item_i.hw_write_address - cfg_i.dma_base;
    cur_aligned  = {cur[RING_W-1:2], 2'b00};
    n_raw        = cur_aligned - rro_q;
    room         = (fill_q < FILL_W'(SOFT_FIFO_BYTES)) ? FILL_W'(SOFT_FIFO_BYTES) - fill_q
                                                       : '0;
    room_aligned = (room != '0) ? ((room - FILL_W'(1)) & ALIGN_KEEP) : '0;
    room_clamp   = NCMP_W'(room) <= NCMP_W'(n_raw);
    n            = room_clamp ? RING_W'(room_aligned) : n_raw;

    ring_sum = {1'b0, rro_q} + {1'b0, n};
    wraps    = ring_sum > (RING_W + 1)'(RING_BYTES);
    to_wrap  = (RING_W + 1)'(RING_BYTES) - {1'b0, rro_q};
    len1     = wraps ? RING_W'(to_wrap) : n;
    len2     = wraps ? n - RING_W'(to_wrap) : '0;

    put_sum  = PSUM_W'(put_q) + PSUM_W'(n);
    put_poll = (put_sum >= PSUM_W'(SOFT_FIFO_BYTES))
             ? FIFO_W'(put_sum - PSUM_W'(SOFT_FIFO_BYTES)) : FIFO_W'(put_sum);
    fill_poll = fill_q + FILL_W'(n);

    iv_up  = {1'b0, interval_q} + {1'b0, cfg_i.interval_step_us};
    if (32'(n) < 32'(cfg_i.busy_threshold)) begin
      iv_raw = iv_up;
    end else begin
      iv_raw = (interval_q > cfg_i.interval_step_us)
             ? {1'b0, interval_q - cfg_i.interval_step_us} : '0;
    end
    if (iv_raw < {1'b0, cfg_i.interval_min_us}) begin
      iv_clamped = cfg_i.interval_min_us;
    end else if (iv_raw > {1'b0, cfg_i.interval_max_us}) begin
      iv_clamped = cfg_i.interval_max_us;
    end else begin
      iv_clamped = iv_raw[19:0];
    end

    retire   = (CCMP_W'(item_i.written_count) < CCMP_W'(fill_q))
             ? FILL_W'(item_i.written_count) : fill_q;
    get_sum  = (FIFO_W + 1)'(get_q) + (FIFO_W + 1)'(retire);
    get_cons = (get_sum >= (FIFO_W + 1)'(SOFT_FIFO_BYTES))
             ? FIFO_W'(get_sum - (FIFO_W + 1)'(SOFT_FIFO_BYTES)) : FIFO_W'(get_sum);
  end

  always_comb begin
    rro_d      = rro_q;
    put_d      = put_q;
    get_d      = get_q;
    fill_d     = fill_q;
    failed_d   = failed_q;
    interval_d = interval_q;
    step_o     = '0;
    case (drc_pkg::op_e'(item_i.opcode))
      drc_pkg::OP_START: begin
        rro_d      = {cur[RING_W-1:2], 2'b00};
        put_d      = '0;
        get_d      = '0;
        fill_d     = '0;
        failed_d   = 1'b0;
        interval_d = drc_pkg::INTERVAL_RESET;
        step_o.copy_source_offset = 21'({cur[RING_W-1:2], 2'b00});
      end
      drc_pkg::OP_POLL: begin
        if (!failed_q) begin
          if (cur[0]) begin
            failed_d             = 1'b1;
            step_o.hard_overflow = 1'b1;
          end else begin
            rro_d      = ring_sum[RING_W-1:0];
            put_d      = put_poll;
            fill_d     = fill_poll;
            interval_d = iv_clamped;
            failed_d   = fill_poll >= SOFT_LIMIT;
            step_o.copy_source_offset = 21'(rro_q);
            step_o.copy_dest_offset   = 29'(put_q);
            step_o.first_length       = 21'(len1);
            step_o.second_length      = 21'(len2);
            step_o.wake_writer        = (fill_q == '0) && (n != '0);
          end
        end
      end
      drc_pkg::OP_CONSUME: begin
        get_d  = get_cons;
        fill_d = fill_q - retire;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rro_q      <= '0;
      put_q      <= '0;
      get_q      <= '0;
      fill_q     <= '0;
      failed_q   <= 1'b0;
      interval_q <= drc_pkg::INTERVAL_RESET;
    end else if (accept_i) begin
      rro_q      <= rro_d;
      put_q      <= put_d;
      get_q      <= get_d;
      fill_q     <= fill_d;
      failed_q   <= failed_d;
      interval_q <= interval_d;
    end
  end

  assign put_o      = put_q;
  assign get_o      = get_q;
  assign fill_o     = fill_q;
  assign failed_o   = failed_q;
  assign interval_o = interval_q;

endmodule

`default_nettype wire
